@@ rtl/buddy_allocator_top_defines.svh @@
// Assertion macros used by the buddy allocator core.
`ifndef BUDDY_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_ALLOCATOR_TOP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BAL_AST_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("buddy allocator check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define BAL_AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("buddy allocator check failed");

`endif

@@ rtl/bal_pkg.sv @@
// Shared constants and helper functions for the buddy allocator.
package bal_pkg;

    localparam int LEVELS    = 10;
    localparam int WORD_W    = 32;
    localparam int WORD_LOG  = 5;
    localparam int IDX_W     = (LEVELS < WORD_LOG) ? WORD_LOG : LEVELS;
    localparam int SCAN_W    = IDX_W - WORD_LOG + 1;
    localparam int LV_W      = $clog2(LEVELS + 1);
    localparam int CNT_W     = LEVELS + 1;
    localparam int LOG_W     = 6;
    localparam int RAM_DEPTH = (LEVELS <= WORD_LOG) ? (LEVELS + 1)
                                                    : ((1 << (LEVELS - WORD_LOG + 1)) + WORD_LOG - 1);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam logic [4:0] MIN_MAX   = 5'(32 - LEVELS);
    localparam logic [4:0] MIN_RESET = 5'd8;
    localparam logic [WORD_W-1:0] WORD_ONE = WORD_W'(1);

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic REG_MIN_LOG2 = 1'b0;

    // First RAM word of a tree level; levels up to WORD_LOG take one word each.
    function automatic logic [RAM_AW-1:0] word_base(input logic [LV_W-1:0] lv);
        int b;
        b = 0;
        if (int'(lv) <= WORD_LOG)
            b = int'(lv);
        else
            b = (1 << (int'(lv) - WORD_LOG)) + WORD_LOG - 1;
        return RAM_AW'(b);
    endfunction

    // RAM word that holds the bit of node idx at level lv.
    function automatic logic [RAM_AW-1:0] word_addr(input logic [LV_W-1:0] lv,
                                                    input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] w;
        w = idx >> WORD_LOG;
        return word_base(lv) + RAM_AW'(w);
    endfunction

endpackage

@@ rtl/buddy_allocator_top.sv @@
// Top level of the buddy allocator: configuration port and allocator core.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request per transfer:
//   func selects allocate or free; request_bytes is used by an allocate,
//   block_offset and block_bytes by a free. Output channel (out_valid /
//   out_stall) returns one result transfer per request that no clearing pass cuts off.
//   Flow: decode comes first; an allocate then scans the words of the
//   chosen level of the node bitmap RAM (up to 32 words) and splits one
//   level at a time (up to 10); a free walks up the tree (up to 11
//   levels). The result is then loaded into the result register. The
//   core takes one item at a time: in_stall stays high until the result
//   of the item in work is loaded.
//   Reset, and any write of min_block_log2 (APB address 0), start a clearing
//   pass over all 68 RAM words that rebuilds a wholly free pool; in_stall
//   stays high meanwhile. A stalled result holds in the output register while
//   the next request is already taken; the core waits at its end only when a
//   second result is ready before the first has been transferred.
module buddy_allocator_top
    import bal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [32:0] request_bytes,
    input  logic [31:0] block_offset,
    input  logic [32:0] block_bytes,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [31:0] out_offset,
    output logic [32:0] out_bytes,
    output logic [32:0] free_bytes,
    output logic [32:0] largest_free
);

    logic [4:0] min_log2_reg, min_log2_next;
    logic       reg_hit;
    logic       cfg_write;
    logic [4:0] wr_val;

    // Register index comes from the word address; byte lanes are ignored.
    assign reg_hit   = (paddr[2] == REG_MIN_LOG2);
    assign cfg_write = psel && penable && pwrite && pready && reg_hit;
    assign pready    = 1'b1;

    // Saturate the minimum block size so the pool stays within 32 address bits.
    assign wr_val = (pwdata[4:0] > MIN_MAX) ? MIN_MAX : pwdata[4:0];

    always_comb
    begin
        min_log2_next = min_log2_reg;
        if (cfg_write)
            min_log2_next = wr_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_log2_reg <= MIN_RESET;
        end
        else
        begin
            min_log2_reg <= min_log2_next;
        end
    end

    assign prdata = reg_hit ? {27'd0, min_log2_reg} : 32'd0;

    // A register write also rebuilds the free map for the new block size.
    bal_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .min_log2      (min_log2_reg),
        .reinit        (cfg_write),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .request_bytes (request_bytes),
        .block_offset  (block_offset),
        .block_bytes   (block_bytes),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .out_offset    (out_offset),
        .out_bytes     (out_bytes),
        .free_bytes    (free_bytes),
        .largest_free  (largest_free)
    );

endmodule

@@ rtl/bal_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bal_core.sv @@
// Sequencer of the buddy allocator: tree bitmap walks, level counts and result register.
`include "buddy_allocator_top_defines.svh"
module bal_core
    import bal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [4:0]  min_log2,
    input  logic        reinit,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [32:0] request_bytes,
    input  logic [31:0] block_offset,
    input  logic [32:0] block_bytes,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [31:0] out_offset,
    output logic [32:0] out_bytes,
    output logic [32:0] free_bytes,
    output logic [32:0] largest_free
);

    typedef enum logic [11:0] {
        S_CLEAR     = 12'b000000000001,
        S_IDLE      = 12'b000000000010,
        S_DECODE    = 12'b000000000100,
        S_PICK      = 12'b000000001000,
        S_SCAN_RD   = 12'b000000010000,
        S_SCAN_CHK  = 12'b000000100000,
        S_SPLIT_CLR = 12'b000001000000,
        S_SPLIT_SET = 12'b000010000000,
        S_FREE_RD   = 12'b000100000000,
        S_FREE_CHK  = 12'b001000000000,
        S_DONE      = 12'b010000000000,
        S_SPARE     = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic              func_reg;
    logic [32:0]       req_reg;
    logic [31:0]       off_reg;
    logic [32:0]       bsz_reg;
    logic [LOG_W-1:0]  clog_reg, clog_next;
    logic [LV_W-1:0]   node_lv_reg, node_lv_next;
    logic [IDX_W-1:0]  node_i_reg, node_i_next;
    logic [LV_W-1:0]   start_lv_reg, start_lv_next;
    logic [SCAN_W-1:0] scan_w_reg, scan_w_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              first_reg, first_next;
    logic              ok_reg, ok_next;
    logic              oom_reg, oom_next;
    logic [CNT_W-1:0]  cnt_reg [0:LEVELS];
    logic [CNT_W-1:0]  cnt_next [0:LEVELS];
    logic [32:0]       free_count_reg, free_count_next;
    logic [RAM_AW-1:0] clr_addr_reg, clr_addr_next;

    logic        out_valid_reg, out_valid_next;
    logic        status_reg;
    logic [31:0] out_offset_reg;
    logic [32:0] out_bytes_reg;
    logic [32:0] free_bytes_reg;
    logic [32:0] largest_reg;

    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [RAM_AW-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic             cnt_inc, cnt_dec;
    logic [LV_W-1:0]  cnt_lv;
    logic             accept, load;

    logic [LOG_W-1:0] pool_log2;
    logic [32:0]      pool;

    // decode helpers
    logic [32:0]      rm1, bmask;
    logic [LOG_W-1:0] hb, lg;
    logic             free_valid;
    logic [LOG_W-1:0] eff, start6;
    logic             found;
    logic [LV_W-1:0]  pick_lv;
    logic [WORD_LOG-1:0] scan_pos;
    logic [WORD_LOG-1:0] bpos, bud_pos;
    logic             bit_i, bit_b;
    logic [IDX_W-1:0] child;
    logic [LV_W-1:0]  lv_up;
    logic [LOG_W-1:0] res_sh, lrg_sh;
    logic [32:0]      res_bytes, res_off_wide;
    logic [LV_W-1:0]  lrg_lv;
    logic             any_free;
    logic [33:0]      fc_sum;
    logic [32:0]      fc_after;

    bal_ram #(
        .WIDTH(WORD_W),
        .DEPTH(RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pool_log2 = LOG_W'(LEVELS) + LOG_W'(min_log2);
    assign pool      = 33'd1 << pool_log2;
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign load      = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign bpos    = node_i_reg[WORD_LOG-1:0];
    assign bud_pos = bpos ^ WORD_LOG'(1);
    assign bit_i   = ram_rdata[bpos];
    assign bit_b   = ram_rdata[bud_pos];
    assign child   = node_i_reg << 1;
    assign lv_up   = node_lv_reg + LV_W'(1);

    // Request decode: ceil(log2) of the request, and checks on a free.
    always_comb
    begin
        rm1   = req_reg - 33'd1;
        bmask = bsz_reg - 33'd1;
        hb    = '0;
        lg    = '0;
        for (int k = 0; k < 33; k++)
        begin
            if (rm1[k])
                hb = LOG_W'(k);
            if (bsz_reg[k])
                lg = LOG_W'(k);
        end
        free_valid = (bsz_reg != 33'd0) && ((bsz_reg & bmask) == 33'd0)
                     && (lg >= LOG_W'(min_log2)) && (lg <= pool_log2)
                     && ((off_reg & bmask[31:0]) == 32'd0)
                     && ({1'b0, off_reg} < pool);
    end

    // Level pick for an allocate: deepest level at or above the fit with a free node.
    always_comb
    begin
        eff     = (clog_reg > LOG_W'(min_log2)) ? clog_reg : LOG_W'(min_log2);
        start6  = pool_log2 - eff;
        found   = 1'b0;
        pick_lv = '0;
        for (int k = 0; k <= LEVELS; k++)
        begin
            if ((LV_W'(k) <= LV_W'(start6)) && (cnt_reg[k] != '0))
            begin
                found   = 1'b1;
                pick_lv = LV_W'(k);
            end
        end
        scan_pos = '0;
        for (int k = WORD_W - 1; k >= 0; k--)
        begin
            if (ram_rdata[k])
                scan_pos = WORD_LOG'(k);
        end
    end

    // Result values and summary of the pool.
    always_comb
    begin
        res_sh       = pool_log2 - LOG_W'(node_lv_reg);
        res_bytes    = 33'd1 << res_sh;
        res_off_wide = 33'(node_i_reg) << res_sh;
        lrg_lv       = '0;
        any_free     = 1'b0;
        for (int k = LEVELS; k >= 0; k--)
        begin
            if (cnt_reg[k] != '0)
            begin
                any_free = 1'b1;
                lrg_lv   = LV_W'(k);
            end
        end
        lrg_sh = pool_log2 - LOG_W'(lrg_lv);
        fc_sum = {1'b0, free_count_reg} + {1'b0, bsz_reg};
        fc_after = free_count_reg;
        if (ok_reg && (func_reg == FUNC_ALLOC))
            fc_after = (free_count_reg >= res_bytes) ? (free_count_reg - res_bytes) : 33'd0;
        else if (ok_reg && (func_reg == FUNC_FREE))
            fc_after = (fc_sum > {1'b0, pool}) ? pool : fc_sum[32:0];
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        clog_next       = clog_reg;
        node_lv_next    = node_lv_reg;
        node_i_next     = node_i_reg;
        start_lv_next   = start_lv_reg;
        scan_w_next     = scan_w_reg;
        word_next       = word_reg;
        first_next      = first_reg;
        ok_next         = ok_reg;
        oom_next        = oom_reg;
        free_count_next = free_count_reg;
        clr_addr_next   = clr_addr_reg;
        ram_we          = 1'b0;
        ram_waddr       = word_addr(node_lv_reg, node_i_reg);
        ram_wdata       = '0;
        ram_raddr       = word_addr(node_lv_reg, node_i_reg);
        cnt_inc         = 1'b0;
        cnt_dec         = 1'b0;
        cnt_lv          = node_lv_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we          = 1'b1;
                ram_waddr       = clr_addr_reg;
                ram_wdata       = (clr_addr_reg == '0) ? WORD_ONE : '0;
                free_count_next = pool;
                clr_addr_next   = clr_addr_reg + RAM_AW'(1);
                if (clr_addr_reg == RAM_AW'(RAM_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                ok_next  = 1'b0;
                oom_next = 1'b0;
                if (func_reg == FUNC_ALLOC)
                begin
                    clog_next  = (req_reg <= 33'd1) ? '0 : (hb + LOG_W'(1));
                    state_next = S_PICK;
                end
                else if (free_valid)
                begin
                    node_lv_next = LV_W'(pool_log2 - lg);
                    node_i_next  = IDX_W'(off_reg >> lg);
                    first_next   = 1'b1;
                    state_next   = S_FREE_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PICK:
            begin
                if ((clog_reg > pool_log2) || !found)
                begin
                    oom_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    node_lv_next  = pick_lv;
                    start_lv_next = LV_W'(start6);
                    scan_w_next   = '0;
                    state_next    = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                ram_raddr  = word_addr(node_lv_reg, IDX_W'(scan_w_reg) << WORD_LOG);
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (ram_rdata != '0)
                begin
                    node_i_next = (IDX_W'(scan_w_reg) << WORD_LOG) | IDX_W'(scan_pos);
                    word_next   = ram_rdata;
                    state_next  = S_SPLIT_CLR;
                end
                else
                begin
                    scan_w_next = scan_w_reg + SCAN_W'(1);
                    state_next  = S_SCAN_RD;
                end
            end
            S_SPLIT_CLR:
            begin
                // take the found block off the free map
                ram_we    = 1'b1;
                ram_wdata = word_reg & ~(WORD_ONE << bpos);
                cnt_dec   = 1'b1;
                ok_next   = 1'b1;
                if (node_lv_reg == start_lv_reg)
                    state_next = S_DONE;
                else
                    state_next = S_SPLIT_SET;
            end
            S_SPLIT_SET:
            begin
                // keep the low half, hand the high half back; that level was empty
                ram_we       = 1'b1;
                ram_waddr    = word_addr(lv_up, child | IDX_W'(1));
                ram_wdata    = WORD_ONE << (child[WORD_LOG-1:0] | WORD_LOG'(1));
                cnt_inc      = 1'b1;
                cnt_lv       = lv_up;
                node_lv_next = lv_up;
                node_i_next  = child;
                if (lv_up == start_lv_reg)
                    state_next = S_DONE;
            end
            S_FREE_RD:
            begin
                state_next = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                if (first_reg && bit_i)
                begin
                    state_next = S_DONE;
                end
                else if ((node_lv_reg != '0) && bit_b)
                begin
                    // merge: drop the buddy and climb one level
                    ram_we       = 1'b1;
                    ram_wdata    = ram_rdata & ~(WORD_ONE << bud_pos);
                    cnt_dec      = 1'b1;
                    node_lv_next = node_lv_reg - LV_W'(1);
                    node_i_next  = node_i_reg >> 1;
                    first_next   = 1'b0;
                    state_next   = S_FREE_RD;
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata | (WORD_ONE << bpos);
                    cnt_inc    = !bit_i;
                    ok_next    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load)
                begin
                    free_count_next = fc_after;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (reinit)
        begin
            state_next    = S_CLEAR;
            clr_addr_next = '0;
        end
    end

    // Per-level free node counts.
    always_comb
    begin
        for (int k = 0; k <= LEVELS; k++)
        begin
            cnt_next[k] = cnt_reg[k];
            if (state_reg == S_CLEAR)
                cnt_next[k] = (k == 0) ? CNT_W'(1) : '0;
            else if (cnt_inc && (LV_W'(k) == cnt_lv))
                cnt_next[k] = cnt_reg[k] + CNT_W'(1);
            else if (cnt_dec && (LV_W'(k) == cnt_lv))
                cnt_next[k] = cnt_reg[k] - CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            free_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int k = 0; k <= LEVELS; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            free_count_reg <= free_count_next;
            out_valid_reg  <= out_valid_next;
            for (int k = 0; k <= LEVELS; k++)
            begin
                cnt_reg[k] <= cnt_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func;
            req_reg  <= request_bytes;
            off_reg  <= block_offset;
            bsz_reg  <= block_bytes;
        end
        clog_reg     <= clog_next;
        node_lv_reg  <= node_lv_next;
        node_i_reg   <= node_i_next;
        start_lv_reg <= start_lv_next;
        scan_w_reg   <= scan_w_next;
        word_reg     <= word_next;
        first_reg    <= first_next;
        ok_reg       <= ok_next;
        oom_reg      <= oom_next;
        if (load)
        begin
            status_reg     <= oom_reg;
            out_offset_reg <= ok_reg ? res_off_wide[31:0] : 32'd0;
            out_bytes_reg  <= ok_reg ? res_bytes : 33'd0;
            free_bytes_reg <= fc_after;
            largest_reg    <= any_free ? (33'd1 << lrg_sh) : 33'd0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_offset   = out_offset_reg;
    assign out_bytes    = out_bytes_reg;
    assign free_bytes   = free_bytes_reg;
    assign largest_free = largest_reg;

    `BAL_AST_NEXT(a_accept_decode, accept && !reinit, state_reg == S_DECODE)
    `BAL_AST_SAME(a_free_count_cap, state_reg == S_IDLE, free_count_reg <= pool)
    `BAL_AST_SAME(a_split_depth, state_reg == S_SPLIT_SET, node_lv_reg < start_lv_reg)

endmodule
